/* rtl/core/edu2x_pkg.sv */
// ----------------------------------------------------------------------------
// edu2x_pkg
// Shared widths, register codes, stage-advance struct and per-byte pixel
// helpers for the 2x edge-directed temporal upscaler.
// ----------------------------------------------------------------------------
package edu2x_pkg;

  localparam int unsigned MaxDimDefault = 4096;

  localparam int unsigned CFG_W   = 13;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned MV_W    = 20;
  localparam int unsigned IDX_W   = 24;

  localparam int unsigned IN_TDATA_W  = 224;
  localparam int unsigned OUT_TDATA_W = 152;

  localparam int unsigned WIDTH_RESET  = 1920;
  localparam int unsigned HEIGHT_RESET = 1080;

  // Configuration register indexes
  localparam logic [0:0] REG_TARGET_WIDTH  = 1'b0;
  localparam logic [0:0] REG_TARGET_HEIGHT = 1'b1;

  // Load enables for the pipeline stages behind the input register
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_adv_t;

  // Per-byte rounding average
  function automatic logic [PIX_W-1:0] avg8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [8:0]       s;
    logic [PIX_W-1:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]} + 9'd1;
      r[8*i +: 8] = s[8:1];
    end
    return r;
  endfunction

  // Per byte: 1 where |here - below_right| < |right - below|
  function automatic logic [3:0] edge_pick(input logic [PIX_W-1:0] here,
                                           input logic [PIX_W-1:0] right,
                                           input logic [PIX_W-1:0] below,
                                           input logic [PIX_W-1:0] br);
    logic [7:0] d1;
    logic [7:0] d2;
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      d1 = (here[8*i +: 8] > br[8*i +: 8]) ? here[8*i +: 8] - br[8*i +: 8]
                                           : br[8*i +: 8] - here[8*i +: 8];
      d2 = (right[8*i +: 8] > below[8*i +: 8]) ? right[8*i +: 8] - below[8*i +: 8]
                                               : below[8*i +: 8] - right[8*i +: 8];
      r[i] = d1 < d2;
    end
    return r;
  endfunction

  function automatic logic [5:0] pop32(input logic [PIX_W-1:0] v);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < PIX_W; i++) begin
      c = c + 6'(v[i]);
    end
    return c;
  endfunction

endpackage

/* rtl/core/edu2x_reproj.sv */
// ----------------------------------------------------------------------------
// edu2x_reproj
// Motion reprojection of the history index: scale motion by the frame size,
// round to nearest even, offset the 2x position, clamp, and linearize.
// ----------------------------------------------------------------------------
module edu2x_reproj import edu2x_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault,
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1)
) (
  input  logic                      clk_i,
  input  stage_adv_t                adv_i,
  input  logic [DIM_W-1:0]          width_i,
  input  logic [DIM_W-1:0]          height_i,
  input  logic [COORD_W-1:0]        col_i,
  input  logic [COORD_W-1:0]        row_i,
  input  logic signed [MV_W-1:0]    mvh_i,
  input  logic signed [MV_W-1:0]    mvv_i,
  output logic [IDX_W-1:0]          idx_o
);

  localparam int unsigned PROD_W = MV_W + DIM_W + 1;
  localparam int unsigned FL_W   = PROD_W - 16;
  localparam int unsigned DW     = FL_W + 1;
  localparam int unsigned VW     = ((DW > COORD_W + 2) ? DW : COORD_W + 2) + 1;
  localparam int unsigned SUM_W  = (2 * DIM_W + 1 > IDX_W) ? 2 * DIM_W + 1 : IDX_W;

  logic signed [PROD_W-1:0] px_q, py_q;
  logic [COORD_W-1:0]       col_q, row_q;
  logic [DIM_W-1:0]         rx_q, ry_q;
  logic [IDX_W-1:0]         idx_q;
  logic [SUM_W-1:0]         sum;

  // Round the scaled motion, subtract from the 2x coordinate, clamp to frame
  function automatic logic [DIM_W-1:0] place(input logic [COORD_W-1:0]      coord,
                                             input logic signed [PROD_W-1:0] p,
                                             input logic [DIM_W-1:0]         dim);
    logic signed [FL_W-1:0] fl;
    logic [15:0]            rem;
    logic                   up;
    logic signed [DW-1:0]   d;
    logic signed [VW-1:0]   v;
    logic [DIM_W-1:0]       r;
    fl  = p[PROD_W-1:16];
    rem = p[15:0];
    up  = (rem > 16'h8000) || ((rem == 16'h8000) && fl[0]);
    d   = DW'(fl) + DW'({1'b0, up});
    v   = VW'({1'b0, coord, 1'b0}) - VW'(d);
    if (v[VW-1]) begin
      r = '0;
    end else if (v[VW-2:0] >= (VW-1)'(dim)) begin
      r = dim - 1'b1;
    end else begin
      r = v[DIM_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      px_q  <= mvh_i * $signed({1'b0, width_i});
      py_q  <= mvv_i * $signed({1'b0, height_i});
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      rx_q <= place(col_q, px_q, width_i);
      ry_q <= place(row_q, py_q, height_i);
    end
  end

  assign sum = SUM_W'(ry_q) * SUM_W'(width_i) + SUM_W'(rx_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      idx_q <= sum[IDX_W-1:0];
    end
  end

  assign idx_o = idx_q;

endmodule

/* rtl/core/edge_directed_2x_upscale_temporal.sv */
// ----------------------------------------------------------------------------
// edge_directed_2x_upscale_temporal
// Top level: 2x upscale of one source pixel per transfer into a 2x2 block,
// with edge-directed diagonal fill, temporal history blend and the
// reprojected history index.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one result per clock while the output
// is not stalled. Four register stages: input register, motion multiply and
// diagonal selects, reprojection clamp and spatial blend, then the index
// multiply-add and history blend into the output register. Each stage holds
// only while the stage after it is full and blocked, so bubbles collapse and
// the input side keeps accepting while a result waits at the output, until all
// four stages are full. The configuration port applies the 1..MAX_DIM
// saturation when a register is written.
module edge_directed_2x_upscale_temporal import edu2x_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // src_col, src_row, pix_here, pix_right, pix_below, pix_below_right,
  // motion_horiz, motion_vert, history_pixel, 2 pad bits
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_top_left, out_top_right, out_bottom_left, out_bottom_right,
  // history_index
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W = CFG_W + 1;
  localparam logic [DIM_W-1:0] W_RST =
    DIM_W'((WIDTH_RESET > MAX_DIM) ? MAX_DIM : WIDTH_RESET);
  localparam logic [DIM_W-1:0] H_RST =
    DIM_W'((HEIGHT_RESET > MAX_DIM) ? MAX_DIM : HEIGHT_RESET);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    if (r == '0) return DIM_W'(1);
    if ({1'b0, r} > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return DIM_W'(r);
  endfunction

  // Configuration
  logic [DIM_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_RST;
      height_q <= H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_WIDTH:  width_q  <= eff_dim(cfg_data_i);
        REG_TARGET_HEIGHT: height_q <= eff_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Handshake: a stage loads when it is empty or its successor loads
  logic       v1_q, v2_q, v3_q, v4_q;
  logic       rdy1, rdy2, rdy3, rdy4;
  stage_adv_t adv;

  assign rdy4 = !v4_q || m_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign adv  = '{s2: rdy2, s3: rdy3, s4: rdy4};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: input register
  logic [COORD_W-1:0]     col1_q, row1_q;
  logic [PIX_W-1:0]       here1_q, right1_q, below1_q, br1_q, hist1_q;
  logic signed [MV_W-1:0] mvh1_q, mvv1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      col1_q   <= s_tdata[10:0];
      row1_q   <= s_tdata[21:11];
      here1_q  <= s_tdata[53:22];
      right1_q <= s_tdata[85:54];
      below1_q <= s_tdata[117:86];
      br1_q    <= s_tdata[149:118];
      mvh1_q   <= s_tdata[169:150];
      mvv1_q   <= s_tdata[189:170];
      hist1_q  <= s_tdata[221:190];
    end
  end

  // Stage 2: averages, per-byte edge picks, popcount compare
  logic [PIX_W-1:0] here2_q, tr2_q, bl2_q, a1_2_q, a2_2_q, hist2_q;
  logic [3:0]       esel2_q;
  logic             spin2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      here2_q <= here1_q;
      tr2_q   <= avg8(here1_q, right1_q);
      bl2_q   <= avg8(here1_q, below1_q);
      a1_2_q  <= avg8(here1_q, br1_q);
      a2_2_q  <= avg8(right1_q, below1_q);
      esel2_q <= edge_pick(here1_q, right1_q, below1_q, br1_q);
      spin2_q <= pop32(br1_q ^ 32'h0101_0101) < pop32(below1_q ^ 32'h0101_0101);
      hist2_q <= hist1_q;
    end
  end

  // Stage 3: spatial blend
  logic [PIX_W-1:0] edge_px, spin_px;
  logic [PIX_W-1:0] here3_q, tr3_q, bl3_q, sp3_q, hist3_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      edge_px[8*i +: 8] = esel2_q[i] ? a1_2_q[8*i +: 8] : a2_2_q[8*i +: 8];
    end
    spin_px = spin2_q ? a2_2_q : a1_2_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      here3_q <= here2_q;
      tr3_q   <= tr2_q;
      bl3_q   <= bl2_q;
      sp3_q   <= avg8(edge_px, spin_px);
      hist3_q <= hist2_q;
    end
  end

  // Stage 4: output register
  logic [PIX_W-1:0] tl4_q, tr4_q, bl4_q, br4_q;
  logic [IDX_W-1:0] idx4;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      tl4_q <= here3_q;
      tr4_q <= tr3_q;
      bl4_q <= bl3_q;
      br4_q <= avg8(sp3_q, hist3_q);
    end
  end

  edu2x_reproj #(
    .MAX_DIM (MAX_DIM)
  ) u_reproj (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .width_i  (width_q),
    .height_i (height_q),
    .col_i    (col1_q),
    .row_i    (row1_q),
    .mvh_i    (mvh1_q),
    .mvv_i    (mvv1_q),
    .idx_o    (idx4)
  );

  assign s_tready = rdy1;
  assign m_tvalid = v4_q;
  assign m_tdata  = {idx4, br4_q, bl4_q, tr4_q, tl4_q};

endmodule

/* rtl/core/edu2x_checker.sv */
// ----------------------------------------------------------------------------
// edu2x_checker
// Port-level checks for the upscaler top level, attached by bind.
// ----------------------------------------------------------------------------
module edu2x_checker import edu2x_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // Stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // An empty output register means every stage can load
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Without backpressure an accepted pixel passes through every stage to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("result missing after four unstalled cycles");

endmodule

bind edge_directed_2x_upscale_temporal edu2x_checker u_edu2x_checker (.*);

/* tb/edge_directed_2x_upscale_temporal_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_directed_2x_upscale_temporal_tb
// Streams source pixels with neighbors, motion and history into the 2x
// upscaler under random idle gaps on both sides and across a range of frame
// sizes, and checks every 2x2 output block and history index against an
// in-bench prediction.
// ----------------------------------------------------------------------------
module edge_directed_2x_upscale_temporal_tb;
  import edu2x_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned PHASE_PIXELS  = 200;
  localparam int unsigned NUM_SETTINGS  = 8;
  localparam logic [31:0] LSB_FLIP      = 32'h0101_0101;

  // Input transfer, MSB first so the struct drops straight onto tdata
  typedef struct packed {
    logic [PIX_W-1:0]   hist;
    logic [MV_W-1:0]    mv;
    logic [MV_W-1:0]    mh;
    logic [PIX_W-1:0]   br;
    logic [PIX_W-1:0]   below;
    logic [PIX_W-1:0]   right;
    logic [PIX_W-1:0]   here;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } src_px_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] bot_right;
    logic [PIX_W-1:0] bot_left;
    logic [PIX_W-1:0] top_right;
    logic [PIX_W-1:0] top_left;
  } block_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [0:0]             cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  src_px_t     pixels_to_send[$];
  block_t      blocks_due[$];
  src_px_t     cur_px;
  bit          busy;
  bit          took;
  int unsigned send_gap;
  int unsigned send_calm;
  int unsigned recv_gap;
  int unsigned recv_calm;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned pixels_sent;
  int unsigned blocks_checked;
  int unsigned errors;
  int unsigned reports;
  int unsigned cycle_count;

  logic [CFG_W-1:0] setting_w[NUM_SETTINGS] =
      '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd640, 13'd4095, 13'd1, 13'd1920};
  logic [CFG_W-1:0] setting_h[NUM_SETTINGS] =
      '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd480, 13'd1, 13'd4095, 13'd1080};

  edge_directed_2x_upscale_temporal uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] byte_mean(logic [31:0] a, logic [31:0] b);
    logic [8:0]  s;
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]} + 9'd1;
      r[8*i +: 8] = s[8:1];
    end
    return r;
  endfunction

  function automatic longint dim_eff(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MaxDimDefault) return MaxDimDefault;
    return longint'(r);
  endfunction

  // motion * dim / 65536, rounded to nearest with ties to even
  function automatic longint motion_shift(longint mvec, longint dim);
    longint p;
    longint fl;
    longint rem;
    p   = mvec * dim;
    fl  = p >>> 16;
    rem = p & 64'hFFFF;
    if (rem > 64'h8000 || (rem == 64'h8000 && fl[0])) fl = fl + 1;
    return fl;
  endfunction

  function automatic longint clamp_to(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic block_t upscale_block(src_px_t p, logic [CFG_W-1:0] wr,
                                           logic [CFG_W-1:0] hr);
    longint      w;
    longint      h;
    longint      rx;
    longint      ry;
    int          d_main;
    int          d_cross;
    logic [31:0] diag_main;
    logic [31:0] diag_cross;
    logic [31:0] edge_pix;
    logic [31:0] spin_pix;
    block_t      b;
    w = dim_eff(wr);
    h = dim_eff(hr);
    diag_main  = byte_mean(p.here, p.br);
    diag_cross = byte_mean(p.right, p.below);
    for (int i = 0; i < 4; i++) begin
      d_main  = int'(p.here[8*i +: 8]) - int'(p.br[8*i +: 8]);
      d_cross = int'(p.right[8*i +: 8]) - int'(p.below[8*i +: 8]);
      if (d_main < 0) d_main = -d_main;
      if (d_cross < 0) d_cross = -d_cross;
      edge_pix[8*i +: 8] = (d_main < d_cross) ? diag_main[8*i +: 8] : diag_cross[8*i +: 8];
    end
    spin_pix = ($countones(p.br ^ LSB_FLIP) < $countones(p.below ^ LSB_FLIP)) ?
               diag_cross : diag_main;
    rx = clamp_to(2 * longint'(p.col) - motion_shift(longint'($signed(p.mh)), w), w - 1);
    ry = clamp_to(2 * longint'(p.row) - motion_shift(longint'($signed(p.mv)), h), h - 1);
    b.top_left  = p.here;
    b.top_right = byte_mean(p.here, p.right);
    b.bot_left  = byte_mean(p.here, p.below);
    b.bot_right = byte_mean(byte_mean(edge_pix, spin_pix), p.hist);
    b.idx       = IDX_W'(ry * w + rx);
    return b;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic src_px_t make_px(int col, int row, logic [31:0] here,
                                      logic [31:0] right, logic [31:0] below,
                                      logic [31:0] br, logic [19:0] mh,
                                      logic [19:0] mv, logic [31:0] hist);
    src_px_t p;
    p.col   = COORD_W'(col);
    p.row   = COORD_W'(row);
    p.here  = here;
    p.right = right;
    p.below = below;
    p.br    = br;
    p.mh    = mh;
    p.mv    = mv;
    p.hist  = hist;
    return p;
  endfunction

  function automatic logic [19:0] rand_motion();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 20'($urandom_range(0, 16383)) - 20'd8192;
    if (r < 70) return 20'($urandom);
    // low half exactly one half: rounding ties whenever the dimension is odd
    if (r < 88) return {4'($urandom), 16'h8000};
    case ($urandom_range(0, 3))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2: return 20'h00000;
      default: return 20'hFFFFF;
    endcase
  endfunction

  function automatic src_px_t rand_px();
    src_px_t p;
    p.col  = COORD_W'($urandom);
    p.row  = COORD_W'($urandom);
    p.here = $urandom;
    p.hist = $urandom;
    if ($urandom_range(0, 1)) begin
      // close neighbors make the per-byte diagonal comparison tight
      p.right = p.here ^ ($urandom & 32'h0707_0707);
      p.below = p.here ^ ($urandom & 32'h0707_0707);
      p.br    = p.here ^ ($urandom & 32'h0707_0707);
    end else begin
      p.right = $urandom;
      p.below = $urandom;
      p.br    = ($urandom_range(0, 7) == 0) ? p.below : $urandom;
    end
    p.mh = rand_motion();
    p.mv = rand_motion();
    return p;
  endfunction

  function automatic int unsigned pick_pause(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 8) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 550) return 0;
    if (r < 930) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic wait_idle();
    while (pixels_to_send.size() != 0 || busy || blocks_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TARGET_WIDTH;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i  <= REG_TARGET_HEIGHT;
    cfg_data_i <= h;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  task automatic report_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, fname, exp_v, act_v);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               blocks_due.size());
      $display("edge_directed_2x_upscale_temporal_tb failed");
      $finish;
    end
    if (rst_ni && s_tvalid && s_tready) begin
      blocks_due.push_back(upscale_block(cur_px, width_reg, height_reg));
      pixels_sent++;
      took = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took) begin
        took     = 1'b0;
        busy     = 1'b0;
        send_gap = pick_pause(send_calm);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixels_to_send.size() != 0) begin
          cur_px = pixels_to_send.pop_front();
          busy   = 1'b1;
        end
      end
      s_tvalid <= busy;
      s_tdata  <= {2'b00, cur_px};
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_pause(recv_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    block_t got;
    block_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = block_t'(m_tdata);
      if (blocks_due.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: result with nothing outstanding: %h", $realtime, m_tdata);
        end
      end else begin
        want = blocks_due.pop_front();
        blocks_checked++;
        report_field("out_top_left", want.top_left, got.top_left);
        report_field("out_top_right", want.top_right, got.top_right);
        report_field("out_bottom_left", want.bot_left, got.bot_left);
        report_field("out_bottom_right", want.bot_right, got.bot_right);
        report_field("history_index", 32'(want.idx), 32'(got.idx));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_TARGET_WIDTH;
    cfg_data_i = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    cur_px     = '0;
    busy       = 1'b0;
    took       = 1'b0;
    send_gap   = 0;
    send_calm  = 0;
    recv_gap   = 0;
    recv_calm  = 0;
    width_reg  = CFG_W'(WIDTH_RESET);
    height_reg = CFG_W'(HEIGHT_RESET);
    pixels_sent    = 0;
    blocks_checked = 0;
    errors         = 0;
    reports        = 0;
    cycle_count    = 0;
    setting_w[NUM_SETTINGS-1] = CFG_W'($urandom_range(2, 4096) | 1);
    setting_h[NUM_SETTINGS-1] = CFG_W'($urandom_range(2, 4096));
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners at the reset frame size
    pixels_to_send.push_back(make_px(0, 0, '0, '0, '0, '0, '0, '0, '0));
    pixels_to_send.push_back(make_px(2047, 2047, '1, '1, '1, '1, 20'h7FFFF, 20'h7FFFF, '1));
    pixels_to_send.push_back(make_px(0, 0, '0, '1, '0, '1, 20'h80000, 20'h80000, '1));
    pixels_to_send.push_back(make_px(2047, 0, '1, '0, '1, '0, '0, '0, '0));
    pixels_to_send.push_back(make_px(959, 539, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C,
                                     32'h4B5A_6978, '0, '0, 32'h8000_0001));
    // equal diagonal differences in every byte pick the cross diagonal
    pixels_to_send.push_back(make_px(10, 20, 32'h1020_3040, 32'hF0E0_D0C0, 32'hF0E0_D0C0,
                                     32'h1020_3040, '0, '0, 32'h7F7F_7F7F));
    // equal popcounts keep the main diagonal
    pixels_to_send.push_back(make_px(30, 40, 32'h0011_2233, 32'hFFEE_DDCC, 32'h5A5A_5A5A,
                                     32'h5A5A_5A5A, 20'h00001, 20'hFFFFF, 32'h0102_0304));
    pixels_to_send.push_back(make_px(50, 60, 32'h8080_8080, 32'h7F7F_7F7F, 32'hFEFE_FEFE,
                                     32'h0101_0101, '0, '0, '0));
    pixels_to_send.push_back(make_px(70, 80, 32'h00FF_7F01, 32'hFF00_8000, 32'h00FF_0080,
                                     32'hFF00_FE02, '0, '0, '1));
    pixels_to_send.push_back(make_px(1023, 1023, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                     32'h5555_5555, 20'h55555, 20'hAAAAA, 32'h5555_5555));
    pixels_to_send.push_back(make_px(1000, 100, 32'h0101_0101, 32'h0202_0202, 32'h0303_0303,
                                     32'h0404_0404, 20'h10000, 20'hF0000, 32'hFFFF_FFFE));
    pixels_to_send.push_back(make_px(1365, 682, 32'h0000_00FF, 32'hFF00_0000, 32'h00FF_0000,
                                     32'h0000_FF00, 20'h08000, 20'hF8000, 32'h00FF_00FF));
    repeat (PHASE_PIXELS) pixels_to_send.push_back(rand_px());

    // Later phases sweep the frame size, including zero and over-range writes
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_idle();
      set_frame(setting_w[s], setting_h[s]);
      repeat (PHASE_PIXELS) pixels_to_send.push_back(rand_px());
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d source pixels over %0d frame sizes (reset size included);",
             pixels_sent, NUM_SETTINGS + 1);
    $display("checked %0d 2x2 blocks with history index, %0d mismatches.",
             blocks_checked, errors);
    if (errors == 0 && blocks_due.size() == 0) begin
      $display("edge_directed_2x_upscale_temporal_tb passed");
    end else begin
      $display("edge_directed_2x_upscale_temporal_tb failed");
    end
    $finish;
  end

endmodule
